// ===== rtl/tlsa_pkg.sv =====
// Package for the two-level bitmap slot allocator.
// Holds function and status codes, widths, the directory update struct and helpers.
// No dependencies.
package tlsa_pkg;

    localparam int MAX_PAGES_DEF = 64;
    localparam int MAX_SLOTS_DEF = 64;

    localparam int PAGE_W  = 6;
    localparam int SLOT_W  = 6;
    localparam int WORD_W  = 64;
    localparam int DEPTH   = 64;
    localparam int COUNT_W = 13;
    localparam int NSLOT_W = 7;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CLOSED   = 3'd1;
    localparam logic [2:0] ST_ILLEGAL  = 3'd2;
    localparam logic [2:0] ST_NOT_OCC  = 3'd3;
    localparam logic [2:0] ST_NO_SPACE = 3'd4;

    localparam logic CFG_FILE_OPEN    = 1'b0;
    localparam logic CFG_SLOTS_IN_USE = 1'b1;

    typedef struct packed {
        logic              en;
        logic [PAGE_W-1:0] page;
        logic              room;
    } dir_upd_t;

    function automatic logic [5:0] lowest_set(input logic [WORD_W-1:0] w);
        logic [5:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/tlsa_slot_ram.sv =====
// Slot occupancy word memory, one word per page.
// Synchronous read into an output register; uses tlsa_pkg.
module tlsa_slot_ram (
    input  logic                          aclk,
    input  logic                          rd_en,
    input  logic [tlsa_pkg::PAGE_W-1:0]   rd_addr,
    output logic [tlsa_pkg::WORD_W-1:0]   rd_data,
    input  logic                          wr_en,
    input  logic [tlsa_pkg::PAGE_W-1:0]   wr_addr,
    input  logic [tlsa_pkg::WORD_W-1:0]   wr_data
);
    import tlsa_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tlsa_page_dir.sv =====
// Page directory: has-room bit per page and lowest-page-with-room search.
// Uses tlsa_pkg for the update struct and the priority encoder.
module tlsa_page_dir (
    input  logic                           aclk,
    input  tlsa_pkg::dir_upd_t             upd,
    input  logic [tlsa_pkg::NSLOT_W-1:0]   pages_in_use,
    output logic                           found,
    output logic [tlsa_pkg::PAGE_W-1:0]    found_page
);
    import tlsa_pkg::*;

    logic [DEPTH-1:0] room_reg;
    logic [DEPTH-1:0] cand;

    always_ff @(posedge aclk) begin
        if (upd.en) begin
            room_reg[upd.page] <= upd.room;
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cand[i] = room_reg[i] && (NSLOT_W'(i) < pages_in_use);
        end
    end

    assign found      = |cand;
    assign found_page = lowest_set(cand);

endmodule

// ===== rtl/two_level_bitmap_slot_allocator_top.sv =====
// Two-level bitmap slot allocator, top level.
// Result path: the slot word read is registered on accept, then write back and the registered result follow at commit.
// A new transaction is not accepted until the slot word RAM read-modify-write of the current one commits.
// A waiting result holds the next write-back, and further input, until the output is taken.
// Reset (aresetn, synchronous): counters cleared, file closed, slots_in_use = 64.
// Slot words and has-room bits are not cleared; pages are initialized when opened.
module two_level_bitmap_slot_allocator_top #(
    parameter int MAX_PAGES = tlsa_pkg::MAX_PAGES_DEF,
    parameter int MAX_SLOTS = tlsa_pkg::MAX_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: func[1:0], page_index[7:2], slot_index[13:8], zero[15:14]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // m_tdata: status[2:0], page_out[8:3], slot_out[14:9], record_count[27:15], zero[31:28]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);
    import tlsa_pkg::*;

    localparam int PAGE_LIMIT = (MAX_PAGES < 64) ? MAX_PAGES : 64;
    localparam int SLOT_LIMIT = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;

    logic                file_open_reg;
    logic [NSLOT_W-1:0]  slots_cfg_reg;
    logic [NSLOT_W-1:0]  pages_reg, pages_next;
    logic [COUNT_W-1:0]  rec_reg, rec_next;
    logic                busy_reg;
    logic [1:0]          func_reg;
    logic [PAGE_W-1:0]   pg_reg;
    logic [SLOT_W-1:0]   sl_reg;
    logic                found_reg;
    logic [PAGE_W-1:0]   fpage_reg;
    logic                m_valid_reg;
    logic [31:0]         m_data_reg;

    logic                s_accept;
    logic                commit;
    logic                found;
    logic [PAGE_W-1:0]   found_page;
    logic [PAGE_W-1:0]   rd_addr;
    logic [WORD_W-1:0]   rd_word;
    logic                wr_en;
    logic [PAGE_W-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;
    dir_upd_t            dir_upd;

    logic [NSLOT_W-1:0]  n_eff;
    logic [WORD_W-1:0]   mask;
    logic [WORD_W-1:0]   free_w;
    logic [SLOT_W-1:0]   ins_slot;
    logic [WORD_W-1:0]   ins_word;
    logic [2:0]          status_c;
    logic [PAGE_W-1:0]   pout_c;
    logic [SLOT_W-1:0]   sout_c;

    assign s_tready  = !busy_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign commit    = busy_reg && (!m_valid_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign rd_addr = (s_tdata[1:0] == FUNC_INSERT) ? found_page : s_tdata[7:2];

    tlsa_slot_ram u_ram (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (rd_addr),
        .rd_data (rd_word),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    tlsa_page_dir u_dir (
        .aclk         (aclk),
        .upd          (dir_upd),
        .pages_in_use (pages_reg),
        .found        (found),
        .found_page   (found_page)
    );

    always_comb begin
        if (slots_cfg_reg == '0) begin
            n_eff = NSLOT_W'(1);
        end else if (slots_cfg_reg > NSLOT_W'(SLOT_LIMIT)) begin
            n_eff = NSLOT_W'(SLOT_LIMIT);
        end else begin
            n_eff = slots_cfg_reg;
        end
        if (n_eff >= NSLOT_W'(WORD_W)) begin
            mask = '1;
        end else begin
            mask = (WORD_W'(1) << n_eff[SLOT_W-1:0]) - WORD_W'(1);
        end
    end

    assign free_w   = ~rd_word & mask;
    assign ins_slot = lowest_set(free_w);
    assign ins_word = rd_word | (WORD_W'(1) << ins_slot);

    always_comb begin
        status_c   = ST_OK;
        pout_c     = pg_reg;
        sout_c     = sl_reg;
        wr_en      = 1'b0;
        wr_addr    = pg_reg;
        wr_data    = rd_word;
        dir_upd    = '0;
        pages_next = pages_reg;
        rec_next   = rec_reg;
        if (!file_open_reg) begin
            status_c = ST_CLOSED;
        end else if (func_reg == FUNC_INSERT) begin
            if (found_reg) begin
                if (free_w == '0) begin
                    status_c = ST_NO_SPACE;
                end else begin
                    wr_en        = commit;
                    wr_addr      = fpage_reg;
                    wr_data      = ins_word;
                    dir_upd.en   = commit;
                    dir_upd.page = fpage_reg;
                    dir_upd.room = |(~ins_word & mask);
                    rec_next     = rec_reg + COUNT_W'(1);
                    pout_c       = fpage_reg;
                    sout_c       = ins_slot;
                end
            end else if (pages_reg >= NSLOT_W'(PAGE_LIMIT)) begin
                status_c = ST_NO_SPACE;
            end else begin
                wr_en        = commit;
                wr_addr      = pages_reg[PAGE_W-1:0];
                wr_data      = WORD_W'(1);
                dir_upd.en   = commit;
                dir_upd.page = pages_reg[PAGE_W-1:0];
                dir_upd.room = (n_eff > NSLOT_W'(1));
                pages_next   = pages_reg + NSLOT_W'(1);
                rec_next     = rec_reg + COUNT_W'(1);
                pout_c       = pages_reg[PAGE_W-1:0];
                sout_c       = '0;
            end
        end else if ({1'b0, pg_reg} >= pages_reg || {1'b0, sl_reg} >= n_eff) begin
            status_c = ST_ILLEGAL;
        end else if (!rd_word[sl_reg]) begin
            status_c = ST_NOT_OCC;
        end else if (func_reg == FUNC_DELETE) begin
            wr_en        = commit;
            wr_data      = rd_word & ~(WORD_W'(1) << sl_reg);
            dir_upd.en   = commit;
            dir_upd.page = pg_reg;
            dir_upd.room = 1'b1;
            if (rec_reg != '0) begin
                rec_next = rec_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_open_reg <= 1'b0;
            slots_cfg_reg <= NSLOT_W'(64);
            pages_reg     <= '0;
            rec_reg       <= '0;
            busy_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_FILE_OPEN:    file_open_reg <= cfg_data[0];
                    CFG_SLOTS_IN_USE: slots_cfg_reg <= cfg_data;
                    default:          file_open_reg <= file_open_reg;
                endcase
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (s_accept) begin
                busy_reg <= 1'b1;
            end
            if (commit) begin
                busy_reg    <= 1'b0;
                m_valid_reg <= 1'b1;
                pages_reg   <= pages_next;
                rec_reg     <= rec_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg  <= s_tdata[1:0];
            pg_reg    <= s_tdata[7:2];
            sl_reg    <= s_tdata[13:8];
            found_reg <= found;
            fpage_reg <= found_page;
        end
        if (commit) begin
            m_data_reg <= {4'b0000, rec_next, sout_c, pout_c, status_c};
        end
    end

    a_one_per_two: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    a_pages_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        pages_reg <= NSLOT_W'(PAGE_LIMIT))
        else $error("pages in use beyond page limit");

    a_closed_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && !file_open_reg) |-> (!wr_en && !dir_upd.en && rec_next == rec_reg))
        else $error("state changed while file closed");

    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(busy_reg))
        else $error("result without a request in flight");

endmodule
